### rtl/phm_pkg.sv
// Package for the peer heartbeat monitor: sizes, command codes, status
// codes, register indexes and the structs between the sequencer and table.
// No dependencies.
package phm_pkg;

   // Group size and derived widths
   localparam int MAX_PEERS = 32;
   localparam int IDX_W     = $clog2(MAX_PEERS);
   localparam int CNT_W     = 6;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int RANK_W   = 8;
   localparam int MAGIC_W  = 32;
   localparam int STATUS_W = 2;
   localparam int LIMIT_W  = 6;
   localparam int TIME_W   = 32;
   localparam int TMO_W    = 31;
   localparam int OWN_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Commands
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK      = 2'd0,
      CMD_HEARTBEAT = 2'd1,
      CMD_CHECK     = 2'd2,
      CMD_LIST      = 2'd3
   } cmd_type;

   // Peer status codes (code 3 may be stored as reported)
   localparam logic [STATUS_W-1:0] ST_ALIVE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SUSPECT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DEAD    = 2'd2;
   localparam logic [1:0]          MISS_LIMIT = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PEER_COUNT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_RANK       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_LIMIT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_MAGIC = 2'd3;

   // Register reset values
   localparam logic [CNT_W-1:0]   RST_PEER_COUNT     = CNT_W'(MAX_PEERS);
   localparam logic [OWN_W-1:0]   RST_OWN_RANK       = '0;
   localparam logic [TMO_W-1:0]   RST_TIMEOUT_LIMIT  = 31'd5000;
   localparam logic [MAGIC_W-1:0] RST_EXPECTED_MAGIC = '0;

   // Sequencer states
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_CHECK,
      SEQ_LIST,
      SEQ_LIST_END
   } seq_state_type;

   // Table command from the sequencer
   typedef struct packed {
      logic                hb_write;
      logic                age_write;
      logic [IDX_W-1:0]    index;
      logic [STATUS_W-1:0] status;
   } tbl_cmd_type;

   // Table status toward the sequencer
   typedef struct packed {
      logic stored_alive;
      logic aged_alive;
   } tbl_stat_type;

endpackage

### rtl/phm_peer_table.sv
// Peer table of the heartbeat monitor: last-seen stamps, miss counts and
// status per peer, plus the shared age subtract and timeout compare unit.
// Depends on phm_pkg.
module phm_peer_table (
   input  logic                         clock,
   input  logic                         reset,
   input  phm_pkg::tbl_cmd_type         tbl_cmd,
   input  logic [phm_pkg::TIME_W-1:0]   now_count,
   input  logic [phm_pkg::TMO_W-1:0]    timeout_limit,
   output phm_pkg::tbl_stat_type        tbl_stat
);
   import phm_pkg::*;

   logic [TIME_W-1:0]   last_seen_ff [MAX_PEERS];
   logic [1:0]          miss_ff      [MAX_PEERS];
   logic [STATUS_W-1:0] status_ff    [MAX_PEERS];

   logic [TIME_W-1:0]   age;
   logic                expired;
   logic [1:0]          miss_in;
   logic [STATUS_W-1:0] status_in;

   // Shared unit: age of the addressed peer against the timeout.
   always_comb begin
      age     = now_count - last_seen_ff[tbl_cmd.index];
      expired = age > {1'b0, timeout_limit};
      if (!expired) begin
         miss_in   = miss_ff[tbl_cmd.index];
         status_in = ST_ALIVE;
      end else begin
         miss_in   = (miss_ff[tbl_cmd.index] == MISS_LIMIT) ? MISS_LIMIT
                     : miss_ff[tbl_cmd.index] + 2'd1;
         status_in = (miss_in == MISS_LIMIT) ? ST_DEAD : ST_SUSPECT;
      end
   end

   assign tbl_stat.aged_alive   = !expired;
   assign tbl_stat.stored_alive = (status_ff[tbl_cmd.index] == ST_ALIVE);

   // Entry updates: a heartbeat stamps the peer, a check ages it.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PEERS; i++) begin
            last_seen_ff[i] <= '0;
            miss_ff[i]      <= '0;
            status_ff[i]    <= ST_ALIVE;
         end
      end else if (tbl_cmd.hb_write) begin
         last_seen_ff[tbl_cmd.index] <= now_count;
         miss_ff[tbl_cmd.index]      <= '0;
         status_ff[tbl_cmd.index]    <= tbl_cmd.status;
      end else if (tbl_cmd.age_write) begin
         miss_ff[tbl_cmd.index]   <= miss_in;
         status_ff[tbl_cmd.index] <= status_in;
      end
   end

endmodule

### rtl/phm_seq.sv
// Command sequencer of the heartbeat monitor: accepts commands, walks the
// peer table one entry a cycle for check and list, and drives result beats.
// Depends on phm_pkg.
module phm_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [phm_pkg::CMD_W-1:0]      req_cmd,
   input  logic [phm_pkg::RANK_W-1:0]     req_sender_rank,
   input  logic [phm_pkg::MAGIC_W-1:0]    req_msg_magic,
   input  logic [phm_pkg::STATUS_W-1:0]   req_reported_status,
   input  logic [phm_pkg::LIMIT_W-1:0]    req_list_limit,
   input  logic [phm_pkg::CNT_W-1:0]      group_size,
   input  logic [phm_pkg::OWN_W-1:0]      own_rank,
   input  logic [phm_pkg::MAGIC_W-1:0]    expected_magic,
   output phm_pkg::tbl_cmd_type           tbl_cmd,
   input  phm_pkg::tbl_stat_type          tbl_stat,
   output logic                           rsp_strobe,
   output logic                           rsp_magic_error,
   output logic [phm_pkg::CNT_W-1:0]      rsp_alive_count,
   output logic [phm_pkg::OWN_W-1:0]      rsp_alive_rank,
   output logic                           rsp_rank_valid,
   output logic                           rsp_last
);
   import phm_pkg::*;

   seq_state_type state_ff, state_in;

   logic [IDX_W-1:0]   index_ff, index_in;
   logic [CNT_W-1:0]   tally_ff, tally_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [OWN_W-1:0]   pend_rank_ff, pend_rank_in;

   logic               strobe_ff, strobe_in;
   logic               merr_ff, merr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [OWN_W-1:0]   rank_ff, rank_in;
   logic               valid_ff, valid_in;
   logic               last_ff, last_in;

   logic               accept;
   logic               at_end;
   logic               is_own;
   logic [CNT_W-1:0]   check_tally;
   logic [CNT_W-1:0]   list_tally;
   logic               list_done;
   logic               magic_ok;
   logic               sender_in_group;

   // Shared conditions of the walk
   assign accept          = start && (state_ff == SEQ_IDLE);
   assign at_end          = ({1'b0, index_ff} == (group_size - CNT_W'(1)));
   assign is_own          = (OWN_W'(index_ff) == own_rank);
   assign check_tally     = tally_ff +
                            CNT_W'(is_own || tbl_stat.aged_alive);
   assign list_tally      = tally_ff + CNT_W'(tbl_stat.stored_alive);
   assign list_done       = at_end || (list_tally == CNT_W'(limit_ff));
   assign magic_ok        = (req_msg_magic == expected_magic);
   assign sender_in_group = (req_sender_rank < RANK_W'(group_size));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept && req_cmd == CMD_CHECK) begin
               state_in = SEQ_CHECK;
            end else if (accept && req_cmd == CMD_LIST && req_list_limit != '0) begin
               state_in = SEQ_LIST;
            end
         end
         SEQ_CHECK: begin
            if (at_end) begin
               state_in = SEQ_IDLE;
            end
         end
         SEQ_LIST: begin
            if (list_done) begin
               state_in = SEQ_LIST_END;
            end
         end
         SEQ_LIST_END: begin
            state_in = SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // Table commands, walk counters and result beats
   always_comb begin
      tbl_cmd.hb_write  = 1'b0;
      tbl_cmd.age_write = 1'b0;
      tbl_cmd.index     = index_ff;
      tbl_cmd.status    = req_reported_status;
      index_in          = index_ff;
      tally_in          = tally_ff;
      limit_in          = limit_ff;
      pend_valid_in     = pend_valid_ff;
      pend_rank_in      = pend_rank_ff;
      strobe_in         = 1'b0;
      merr_in           = 1'b0;
      count_in          = '0;
      rank_in           = '0;
      valid_in          = 1'b0;
      last_in           = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: begin
            index_in      = '0;
            tally_in      = '0;
            limit_in      = req_list_limit;
            pend_valid_in = 1'b0;
            tbl_cmd.index = req_sender_rank[IDX_W-1:0];
            if (accept && req_cmd == CMD_HEARTBEAT) begin
               tbl_cmd.hb_write = magic_ok && sender_in_group;
               strobe_in        = 1'b1;
               merr_in          = !magic_ok;
               last_in          = 1'b1;
            end else if (accept && req_cmd == CMD_LIST && req_list_limit == '0) begin
               strobe_in = 1'b1;
               last_in   = 1'b1;
            end
         end
         SEQ_CHECK: begin
            tbl_cmd.age_write = !is_own;
            tally_in          = check_tally;
            index_in          = index_ff + IDX_W'(1);
            if (at_end) begin
               strobe_in = 1'b1;
               count_in  = check_tally;
               last_in   = 1'b1;
            end
         end
         SEQ_LIST: begin
            tally_in = list_tally;
            index_in = index_ff + IDX_W'(1);
            if (tbl_stat.stored_alive) begin
               // A newer hit shows the held one is not the final beat.
               strobe_in     = pend_valid_ff;
               rank_in       = pend_rank_ff;
               valid_in      = pend_valid_ff;
               pend_valid_in = 1'b1;
               pend_rank_in  = OWN_W'(index_ff);
            end
         end
         SEQ_LIST_END: begin
            strobe_in = 1'b1;
            rank_in   = pend_valid_ff ? pend_rank_ff : '0;
            valid_in  = pend_valid_ff;
            last_in   = 1'b1;
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         strobe_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         strobe_ff     <= strobe_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff     <= index_in;
      tally_ff     <= tally_in;
      limit_ff     <= limit_in;
      pend_rank_ff <= pend_rank_in;
      merr_ff      <= merr_in;
      count_ff     <= count_in;
      rank_ff      <= rank_in;
      valid_ff     <= valid_in;
      last_ff      <= last_in;
   end

   assign busy            = (state_ff != SEQ_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_magic_error = merr_ff;
   assign rsp_alive_count = count_ff;
   assign rsp_alive_rank  = rank_ff;
   assign rsp_rank_valid  = valid_ff;
   assign rsp_last        = last_ff;

   // A tick never produces a beat.
   a_tick_silent: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == CMD_TICK |=> !rsp_strobe)
      else $error("tick produced a result beat");

   // A heartbeat answers with a single final beat on the next cycle.
   a_hb_beat: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == CMD_HEARTBEAT |=> rsp_strobe && rsp_last)
      else $error("heartbeat result missing");

   // Only list beats carry a rank, and they carry no count.
   a_rank_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_rank_valid |-> rsp_alive_count == '0 && !rsp_magic_error)
      else $error("list beat carries a count or error");

   // Beats without a rank are always the final beat of their command.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_rank_valid |-> rsp_last)
      else $error("rankless beat not final");

endmodule

### rtl/peer_heartbeat_monitor_core.sv
// Top level of the peer heartbeat monitor: configuration registers, the
// millisecond counter, the command sequencer and the peer table.
// Depends on phm_pkg, phm_peer_table and phm_seq.
//
// Usage: a command is taken on a clock edge with start high and busy low.
// Commands are tick (advance the ms counter), heartbeat (record a peer),
// check (age all peers but the own rank, report the alive count) and list (report alive
// ranks in ascending order, up to req_list_limit).
// Results leave as beats on the rsp_ ports, each valid for the one cycle in
// which rsp_strobe is high; the receiver cannot stall, so beats are never
// held. rsp_last marks the final beat of a command.
// Timing: a tick gives no beat. A heartbeat's beat follows on the next
// cycle. A check visits one peer entry a cycle through the shared age
// compare unit, over every peer of the group; its beat follows the last
// visit. A list visits one entry a cycle until the group ends or the limit
// is reached, then gives the final beat from the SEQ_LIST_END state; a zero
// limit answers from idle without a walk. busy is high while a walk runs.
// Reset is synchronous: registers return to their defaults, every peer is
// alive with zero stamps and misses, and the block is ready at once.
// Configuration writes through the csr_ port take effect on the next edge.
module peer_heartbeat_monitor_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [phm_pkg::CMD_W-1:0]       req_cmd,
   input  logic [phm_pkg::RANK_W-1:0]      req_sender_rank,
   input  logic [phm_pkg::MAGIC_W-1:0]     req_msg_magic,
   input  logic [phm_pkg::STATUS_W-1:0]    req_reported_status,
   input  logic [phm_pkg::LIMIT_W-1:0]     req_list_limit,
   output logic                            rsp_strobe,
   output logic                            rsp_magic_error,
   output logic [phm_pkg::CNT_W-1:0]       rsp_alive_count,
   output logic [phm_pkg::OWN_W-1:0]       rsp_alive_rank,
   output logic                            rsp_rank_valid,
   output logic                            rsp_last,
   input  logic                            csr_write_enable,
   input  logic [phm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [phm_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import phm_pkg::*;

   logic [CNT_W-1:0]   peer_count_ff;
   logic [OWN_W-1:0]   own_rank_ff;
   logic [TMO_W-1:0]   timeout_ff;
   logic [MAGIC_W-1:0] magic_ff;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [CNT_W-1:0]   group_size;
   tbl_cmd_type        tbl_cmd;
   tbl_stat_type       tbl_stat;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         peer_count_ff <= RST_PEER_COUNT;
         own_rank_ff   <= RST_OWN_RANK;
         timeout_ff    <= RST_TIMEOUT_LIMIT;
         magic_ff      <= RST_EXPECTED_MAGIC;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PEER_COUNT:     peer_count_ff <= csr_write_data[CNT_W-1:0];
            CSR_OWN_RANK:       own_rank_ff   <= csr_write_data[OWN_W-1:0];
            CSR_TIMEOUT_LIMIT:  timeout_ff    <= csr_write_data[TMO_W-1:0];
            CSR_EXPECTED_MAGIC: magic_ff      <= csr_write_data[MAGIC_W-1:0];
            default:            peer_count_ff <= peer_count_ff;
         endcase
      end
   end

   // Effective group size: zero acts as one, large values clamp.
   always_comb begin
      priority if (peer_count_ff == '0) begin
         group_size = CNT_W'(1);
      end else if (peer_count_ff > CNT_W'(MAX_PEERS)) begin
         group_size = CNT_W'(MAX_PEERS);
      end else begin
         group_size = peer_count_ff;
      end
   end

   // Millisecond counter, wraps freely.
   assign now_in = (start && !busy && req_cmd == CMD_TICK) ? now_ff + TIME_W'(1) : now_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;
      end else begin
         now_ff <= now_in;
      end
   end

   phm_seq u_seq (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_sender_rank     (req_sender_rank),
      .req_msg_magic       (req_msg_magic),
      .req_reported_status (req_reported_status),
      .req_list_limit      (req_list_limit),
      .group_size          (group_size),
      .own_rank            (own_rank_ff),
      .expected_magic      (magic_ff),
      .tbl_cmd             (tbl_cmd),
      .tbl_stat            (tbl_stat),
      .rsp_strobe          (rsp_strobe),
      .rsp_magic_error     (rsp_magic_error),
      .rsp_alive_count     (rsp_alive_count),
      .rsp_alive_rank      (rsp_alive_rank),
      .rsp_rank_valid      (rsp_rank_valid),
      .rsp_last            (rsp_last)
   );

   phm_peer_table u_table (
      .clock         (clock),
      .reset         (reset),
      .tbl_cmd       (tbl_cmd),
      .now_count     (now_ff),
      .timeout_limit (timeout_ff),
      .tbl_stat      (tbl_stat)
   );

endmodule
